[src/optb_pkg.sv]
`timescale 1ns / 1ps
package optb_pkg;
    localparam int DefaultSlots = 16;
    localparam int MaxFires = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_REG   = 2'd1,
        CMD_UNREG = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_FIRE  = 2'd0,
        KIND_REG   = 2'd1,
        KIND_UNREG = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_INVAL  = 2'd1,
        ST_NOSLOT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SCAN = 2'd1,
        BK_ONE  = 2'd2
    } bk_state_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        cmd_t        cmd;
        logic        bad;
        logic        periodic;
        logic        notify;
        logic [31:0] delay;
        logic [31:0] data;
        logic [4:0]  id;
    } op_t;
endpackage

[src/optb_front.sv]
`timescale 1ns / 1ps
module optb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    command,
    input  logic [31:0]   delay,
    input  logic [1:0]    mode,
    input  logic          has_callback,
    input  logic [31:0]   user_data,
    input  logic [4:0]    slot_id,
    input  logic          pop,
    output logic          q_valid,
    output optb_pkg::op_t q_op,
    output logic          busy
);
    import optb_pkg::*;

    // Two-entry queue between classification and execution; at most one entry is ever occupied.
    op_t        mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    op_t        op_in;

    assign busy = (cnt_reg != 2'd0);
    assign push = start && !busy;

    always_comb
    begin
        op_in.cmd      = cmd_t'(command);
        op_in.bad      = (command == CMD_REG) ? (delay[31] || (mode != 2'd1 && mode != 2'd2))
                                              : slot_id[4];
        op_in.periodic = (mode == 2'd2);
        op_in.notify   = has_callback;
        op_in.delay    = delay;
        op_in.data     = user_data;
        op_in.id       = slot_id;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= op_in;
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = mem_reg[rd_ptr_reg];
endmodule

[src/optb_back.sv]
`timescale 1ns / 1ps
module optb_back #(
    parameter int TIMER_SLOTS = optb_pkg::DefaultSlots
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  optb_pkg::op_t q_op,
    output logic          pop,
    output logic          strobe,
    output logic [1:0]    kind,
    output logic [1:0]    status,
    output logic [3:0]    id_out,
    output logic [31:0]   data_out,
    output logic [31:0]   expiry,
    output logic          last
);
    import optb_pkg::*;

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    logic [TIMER_SLOTS-1:0] used_reg, enabled_reg, periodic_reg, notify_reg;
    logic [31:0] exp_reg [TIMER_SLOTS];
    logic [30:0] per_reg [TIMER_SLOTS];
    logic [31:0] dat_reg [TIMER_SLOTS];
    logic [31:0] tick_reg;

    bk_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg;
    logic [4:0]    fires_reg;
    op_t           op_reg;
    // Pending fire held back until the next fire or the end of the scan so that last can be set on the final one.
    logic          pend_reg;
    logic [3:0]    pend_id_reg;
    logic [31:0]   pend_dat_reg;

    logic          strobe_reg, last_reg;
    logic [1:0]    kind_reg, status_reg;
    logic [3:0]    id_reg;
    logic [31:0]   data_reg, expiry_reg;

    logic [SW-1:0] si;
    logic          due, fire, scan_end;
    logic [SW-1:0] free_idx;
    logic          free_found;
    logic [SW-1:0] qi;
    logic          qi_ok;

    assign si  = idx_reg[SW-1:0];
    assign due = used_reg[si] && enabled_reg[si] && !(exp_reg[si] > tick_reg)
                 && (fires_reg < 5'(MaxFires));
    assign fire = due && notify_reg[si];
    assign scan_end = (idx_reg == CW'(TIMER_SLOTS - 1));

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    assign qi    = SW'(op_reg.id[3:0]);
    assign qi_ok = !op_reg.bad && (int'(op_reg.id[3:0]) < TIMER_SLOTS) && used_reg[qi];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (q_valid) state_next = (q_op.cmd == CMD_TICK) ? BK_SCAN : BK_ONE;
            BK_SCAN: if (scan_end) state_next = BK_IDLE;
            BK_ONE:  state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    assign pop = (state_reg == BK_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            used_reg    <= '0;
            enabled_reg <= '0;
            tick_reg    <= '0;
            idx_reg     <= '0;
            fires_reg   <= '0;
            pend_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= 1'b0;
            unique case (state_reg)
                BK_IDLE:
                begin
                    if (pop && q_op.cmd == CMD_TICK)
                    begin
                        tick_reg  <= tick_reg + 32'd1;
                        idx_reg   <= '0;
                        fires_reg <= '0;
                    end
                end
                BK_SCAN:
                begin
                    if (due && !periodic_reg[si] && notify_reg[si])
                        enabled_reg[si] <= 1'b0;
                    if (fire)
                        fires_reg <= fires_reg + 5'd1;
                    idx_reg <= idx_reg + CW'(1);
                    if (fire && pend_reg)
                    begin
                        strobe_reg <= 1'b1;
                        last_reg   <= 1'b0;
                    end
                    else if (!fire && pend_reg && scan_end)
                    begin
                        strobe_reg <= 1'b1;
                        last_reg   <= 1'b1;
                    end
                    if (fire)
                    begin
                        pend_reg     <= 1'b1;
                        pend_id_reg  <= 4'(si);
                        pend_dat_reg <= dat_reg[si];
                    end
                    else if (scan_end)
                        pend_reg <= 1'b0;
                end
                BK_ONE:
                begin
                    strobe_reg <= 1'b1;
                    last_reg   <= 1'b1;
                    unique case (op_reg.cmd)
                        CMD_REG:
                            if (!op_reg.bad && free_found)
                            begin
                                used_reg[free_idx]    <= 1'b1;
                                enabled_reg[free_idx] <= 1'b1;
                            end
                        CMD_UNREG:
                            if (qi_ok)
                            begin
                                used_reg[qi]    <= 1'b0;
                                enabled_reg[qi] <= 1'b0;
                            end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            // A final fire found on the last slot stays pending and goes out from the idle state.
            if (state_reg == BK_SCAN && scan_end && fire)
                pend_reg <= 1'b1;
            if (state_reg == BK_IDLE && pend_reg)
            begin
                strobe_reg <= 1'b1;
                last_reg   <= 1'b1;
                pend_reg   <= 1'b0;
            end
        end
    end

    // Payload and slot storage.
    always_ff @(posedge clk)
    begin
        if (pop)
            op_reg <= q_op;
        if (state_reg == BK_SCAN && due && periodic_reg[si])
            exp_reg[si] <= tick_reg + {1'b0, per_reg[si]};
        if (state_reg == BK_ONE && op_reg.cmd == CMD_REG && !op_reg.bad && free_found)
        begin
            periodic_reg[free_idx] <= op_reg.periodic;
            notify_reg[free_idx]   <= op_reg.notify;
            exp_reg[free_idx]      <= tick_reg + op_reg.delay;
            per_reg[free_idx]      <= op_reg.delay[30:0];
            dat_reg[free_idx]      <= op_reg.data;
        end
        kind_reg   <= KIND_FIRE;
        status_reg <= ST_OK;
        id_reg     <= pend_id_reg;
        data_reg   <= pend_dat_reg;
        expiry_reg <= '0;
        if (state_reg == BK_ONE)
        begin
            kind_reg <= op_reg.cmd;
            data_reg <= '0;
            id_reg   <= '0;
            if (op_reg.cmd == CMD_REG)
            begin
                if (op_reg.bad)
                    status_reg <= ST_INVAL;
                else if (!free_found)
                    status_reg <= ST_NOSLOT;
                else
                    id_reg <= 4'(free_idx);
            end
            else if (!qi_ok)
                status_reg <= ST_INVAL;
            else
            begin
                id_reg <= op_reg.id[3:0];
                if (op_reg.cmd == CMD_QUERY)
                    expiry_reg <= exp_reg[qi];
            end
        end
    end

    assign strobe   = strobe_reg;
    assign kind     = kind_reg;
    assign status   = status_reg;
    assign id_out   = id_reg;
    assign data_out = data_reg;
    assign expiry   = expiry_reg;
    assign last     = last_reg;
endmodule

[src/oneshot_periodic_timer_bank_top.sv]
`timescale 1ns / 1ps
// Channel   Signals                                            Handshake
// command   command delay mode has_callback user_data slot_id  start high, busy low
// result    kind status id_out data_out expiry last            strobe, one cycle
//
// A tick keeps the back half while it is picked up and while the back half walks over
// the slot registers, which sets the rate. Its last fire beat reaches the ports after
// the walk ends. Other commands are picked up into the op register, handled in the
// single-op state and answered from the result registers.
// Reset is asynchronous and clears the tick counter and all used and enabled bits.
// Results cannot be held off; each one is on the ports for one cycle with strobe.
// busy stays high while a command waits in the queue between the two halves.
module oneshot_periodic_timer_bank_top #(
    parameter int TIMER_SLOTS = optb_pkg::DefaultSlots
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] delay,
    input  logic [1:0]  mode,
    input  logic        has_callback,
    input  logic [31:0] user_data,
    input  logic [4:0]  slot_id,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [3:0]  id_out,
    output logic [31:0] data_out,
    output logic [31:0] expiry,
    output logic        last
);
    import optb_pkg::*;

    logic q_valid, pop;
    op_t  q_op;

    // The front half classifies each command beat and queues it.
    optb_front u_front (
        .clk, .rst_n, .start, .command, .delay, .mode, .has_callback,
        .user_data, .slot_id, .pop, .q_valid, .q_op, .busy
    );

    // The back half owns the slot table and produces every result beat.
    optb_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
        .clk, .rst_n, .q_valid, .q_op, .pop, .strobe, .kind, .status,
        .id_out, .data_out, .expiry, .last
    );
endmodule

[tb/oneshot_periodic_timer_bank_top_test.sv]
`timescale 1ns / 1ps
module oneshot_periodic_timer_bank_top_test;
    import optb_pkg::*;

    localparam int NumSlots = 16;
    localparam int MaxFireEvents = 16;
    localparam int CycleLimit = 400000;

    // One expected result beat on the result side.
    typedef struct {
        kind_t       kind;
        status_t     status;
        logic [3:0]  id;
        logic [31:0] data;
        logic [31:0] expiry;
        logic        last;
    } timer_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [31:0] delay;
    logic [1:0]  mode;
    logic        has_callback;
    logic [31:0] user_data;
    logic [4:0]  slot_id;
    logic        strobe;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  id_out;
    logic [31:0] data_out;
    logic [31:0] expiry;
    logic        last;

    // Private copy of the timer bank state, advanced once per accepted command beat.
    logic [31:0] bank_ticks;
    logic        bank_used [NumSlots];
    logic        bank_enabled [NumSlots];
    logic        bank_periodic [NumSlots];
    logic        bank_notify [NumSlots];
    logic [31:0] bank_expiry [NumSlots];
    logic [30:0] bank_period [NumSlots];
    logic [31:0] bank_data [NumSlots];

    timer_result_t pending_results[$];
    int  fail_count;
    int  cycle_count;
    int  idle_percent;

    oneshot_periodic_timer_bank_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .delay        (delay),
        .mode         (mode),
        .has_callback (has_callback),
        .user_data    (user_data),
        .slot_id      (slot_id),
        .strobe       (strobe),
        .kind         (kind),
        .status       (status),
        .id_out       (id_out),
        .data_out     (data_out),
        .expiry       (expiry),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // The run ends here if the design stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("oneshot_periodic_timer_bank_top_test NOT OK");
            $finish;
        end
    end

    // Appends one expected result beat.
    function automatic void push_result(kind_t k, status_t s, logic [3:0] id,
                                        logic [31:0] d, logic [31:0] e);
        timer_result_t r;
        r.kind = k;
        r.status = s;
        r.id = id;
        r.data = d;
        r.expiry = e;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Applies one command to the private bank state and queues its results.
    function automatic void predict_timer_bank(cmd_t cmd, logic [31:0] dly, logic [1:0] md,
                                               logic cb, logic [31:0] ud, logic [4:0] tid);
        int before_count;
        int fires;
        int free_slot;
        int slot;
        before_count = pending_results.size();
        fires = 0;
        free_slot = -1;
        slot = -1;
        case (cmd)
            CMD_TICK:
            begin
                bank_ticks = bank_ticks + 32'd1;
                for (int i = 0; i < NumSlots && fires < MaxFireEvents; i++)
                begin
                    if (bank_used[i] && bank_enabled[i] && bank_expiry[i] <= bank_ticks)
                    begin
                        if (bank_periodic[i])
                        begin
                            if (bank_notify[i])
                            begin
                                push_result(KIND_FIRE, ST_OK, 4'(i), bank_data[i], 32'd0);
                                fires++;
                            end
                            bank_expiry[i] = bank_ticks + {1'b0, bank_period[i]};
                        end
                        else if (bank_notify[i])
                        begin
                            bank_enabled[i] = 1'b0;
                            push_result(KIND_FIRE, ST_OK, 4'(i), bank_data[i], 32'd0);
                            fires++;
                        end
                    end
                end
            end
            CMD_REG:
            begin
                // The delay sign is checked before the mode, then a free slot is sought.
                if (dly[31] || (md != 2'd1 && md != 2'd2))
                begin
                    push_result(KIND_REG, ST_INVAL, 4'd0, 32'd0, 32'd0);
                end
                else
                begin
                    for (int i = NumSlots - 1; i >= 0; i--)
                    begin
                        if (!bank_used[i])
                        begin
                            free_slot = i;
                        end
                    end
                    if (free_slot < 0)
                    begin
                        push_result(KIND_REG, ST_NOSLOT, 4'd0, 32'd0, 32'd0);
                    end
                    else
                    begin
                        bank_used[free_slot] = 1'b1;
                        bank_enabled[free_slot] = 1'b1;
                        bank_periodic[free_slot] = (md == 2'd2);
                        bank_notify[free_slot] = cb;
                        bank_expiry[free_slot] = bank_ticks + dly;
                        bank_period[free_slot] = dly[30:0];
                        bank_data[free_slot] = ud;
                        push_result(KIND_REG, ST_OK, 4'(free_slot), 32'd0, 32'd0);
                    end
                end
            end
            default:
            begin
                if (!tid[4] && bank_used[tid[3:0]])
                begin
                    slot = int'(tid[3:0]);
                end
                if (slot < 0)
                begin
                    push_result(kind_t'(cmd), ST_INVAL, 4'd0, 32'd0, 32'd0);
                end
                else if (cmd == CMD_UNREG)
                begin
                    bank_used[slot] = 1'b0;
                    bank_enabled[slot] = 1'b0;
                    push_result(KIND_UNREG, ST_OK, 4'(slot), 32'd0, 32'd0);
                end
                else
                begin
                    push_result(KIND_QUERY, ST_OK, 4'(slot), 32'd0, bank_expiry[slot]);
                end
            end
        endcase
        // A quiet tick adds nothing; otherwise the final beat carries last.
        if (pending_results.size() > before_count)
        begin
            pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endfunction

    // Sends one command beat, possibly after a random gap, and predicts it on acceptance.
    task automatic send_command(cmd_t cmd, logic [31:0] dly, logic [1:0] md, logic cb,
                                logic [31:0] ud, logic [4:0] tid);
        while (idle_percent > 0 && $urandom_range(99, 0) < idle_percent)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        delay <= dly;
        mode <= md;
        has_callback <= cb;
        user_data <= ud;
        slot_id <= tid;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_timer_bank(cmd, dly, md, cb, ud, tid);
    endtask

    // Waits until every expected beat has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (NumSlots + 4) @(posedge clk);
    endtask

    // Compares every result beat with the oldest expectation.
    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat kind=%0d id=%0d", kind, id_out);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind expected %0d actual %0d", want.kind, kind);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    fail_count++;
                end
                if (id_out !== want.id)
                begin
                    $error("id_out expected %0d actual %0d", want.id, id_out);
                    fail_count++;
                end
                if (data_out !== want.data)
                begin
                    $error("data_out expected %h actual %h", want.data, data_out);
                    fail_count++;
                end
                if (expiry !== want.expiry)
                begin
                    $error("expiry expected %h actual %h", want.expiry, expiry);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_tick();
        send_command(CMD_TICK, $urandom(), 2'($urandom), 1'($urandom), $urandom(),
                     5'($urandom));
    endtask

    // Registers, replies, bad ids and a full bank.
    task automatic test_directed();
        send_command(CMD_REG, 32'h8000_0000, 2'd1, 1'b1, 32'hFFFF_FFFF, 5'd0);
        send_command(CMD_REG, 32'd3, 2'd0, 1'b1, 32'd1, 5'd0);
        send_command(CMD_REG, 32'd3, 2'd3, 1'b1, 32'd1, 5'd0);
        send_command(CMD_REG, 32'd0, 2'd1, 1'b1, 32'hFFFF_FFFF, 5'd0);
        send_command(CMD_REG, 32'd2, 2'd2, 1'b1, 32'hA5A5_5A5A, 5'd0);
        send_command(CMD_REG, 32'd1, 2'd1, 1'b0, 32'h1234_5678, 5'd0);
        send_command(CMD_REG, 32'h7FFF_FFFF, 2'd2, 1'b0, 32'd0, 5'd0);
        send_command(CMD_QUERY, 32'd0, 2'd0, 1'b0, 32'd0, 5'd3);
        send_command(CMD_QUERY, 32'd0, 2'd0, 1'b0, 32'd0, 5'b10000);
        send_command(CMD_UNREG, 32'd0, 2'd0, 1'b0, 32'd0, 5'd15);
        send_command(CMD_UNREG, 32'd0, 2'd0, 1'b0, 32'd0, 5'b11111);
        repeat (4) send_tick();
        send_command(CMD_QUERY, 32'd0, 2'd0, 1'b0, 32'd0, 5'd0);
        for (int i = 0; i < NumSlots; i++)
        begin
            send_command(CMD_REG, 32'd1, 2'd2, 1'b1, $urandom(), 5'd0);
        end
        send_tick();
        for (int i = 0; i < NumSlots; i++)
        begin
            send_command(CMD_UNREG, 32'd0, 2'd0, 1'b0, 32'd0, 5'(i));
        end
        drain_results();
    endtask

    // Mostly well-formed traffic on all slots, with some noise.
    task automatic test_random(int count);
        logic [31:0] dly;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            idle_percent = (n >= count / 3 && n < count / 2) ? 0 : 25;
            pick = $urandom_range(99, 0);
            if (pick < 45)
            begin
                send_tick();
            end
            else if (pick < 70)
            begin
                dly = $urandom_range(9, 0);
                if ($urandom_range(19, 0) == 0)
                begin
                    dly = $urandom();
                end
                send_command(CMD_REG, dly,
                             ($urandom_range(9, 0) == 0) ? 2'($urandom)
                                                         : 2'($urandom_range(2, 1)),
                             ($urandom_range(4, 0) != 0), $urandom(), 5'($urandom));
            end
            else
            begin
                send_command(($urandom_range(1, 0) != 0) ? CMD_UNREG : CMD_QUERY, $urandom(),
                             2'($urandom), 1'($urandom), $urandom(),
                             ($urandom_range(9, 0) == 0) ? 5'($urandom)
                                                         : 5'($urandom_range(15, 0)));
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_TICK;
        delay = 32'd0;
        mode = 2'd0;
        has_callback = 1'b0;
        user_data = 32'd0;
        slot_id = 5'd0;
        fail_count = 0;
        cycle_count = 0;
        idle_percent = 25;
        bank_ticks = 32'd0;
        for (int i = 0; i < NumSlots; i++)
        begin
            bank_used[i] = 1'b0;
            bank_enabled[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(270);

        if (fail_count == 0)
        begin
            $display("oneshot_periodic_timer_bank_top_test OK");
        end
        else
        begin
            $display("oneshot_periodic_timer_bank_top_test NOT OK");
        end
        $finish;
    end
endmodule

[oneshot_periodic_timer_bank_top.f]
src/optb_pkg.sv
src/optb_front.sv
src/optb_back.sv
src/oneshot_periodic_timer_bank_top.sv
tb/oneshot_periodic_timer_bank_top_test.sv
